// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies a property in the same cycle
`define LRLP_ASSERT_NOW(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("lrlp assertion failed");

// condition implies a property in the next cycle
`define LRLP_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("lrlp assertion failed");

`endif

// ===== rtl/lrlp_pkg.sv =====
// shared types, constants and helpers of the log record line parser
package lrlp_pkg;

	localparam int LEN_WIDTH          = 16;
	localparam int NUMBER_FIELD_CHARS = 50;
	localparam int COOKIE_MAX         = 8;
	localparam int FC_W               = $clog2(NUMBER_FIELD_CHARS + 1);
	localparam int CI_W               = $clog2(COOKIE_MAX + 2);
	localparam int CSEL_W             = (COOKIE_MAX > 1) ? $clog2(COOKIE_MAX) : 1;
	localparam int ACC_W              = 64;
	localparam int QUEUE_DEPTH        = 4;
	localparam int QPTR_W             = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam logic [1:0] KIND_URI    = 2'd0;
	localparam logic [1:0] KIND_BODY   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] ST_CMD   = 2'd0;
	localparam logic [1:0] ST_TS    = 2'd1;
	localparam logic [1:0] ST_SHORT = 2'd2;
	localparam logic [1:0] ST_BAD   = 2'd3;

	localparam logic [2:0] CFG_HEAD_COOKIE     = 3'd0;
	localparam logic [2:0] CFG_HEAD_COOKIE_LEN = 3'd1;
	localparam logic [2:0] CFG_TAIL_COOKIE     = 3'd2;
	localparam logic [2:0] CFG_TAIL_COOKIE_LEN = 3'd3;
	localparam logic [2:0] CFG_MARK_CHAR       = 3'd4;
	localparam logic [2:0] CFG_STAMP_CHAR      = 3'd5;

	typedef enum logic [3:0] {
		PH_HEAD, PH_FIRST, PH_VERB, PH_TIME, PH_STAMP, PH_ULEN, PH_URI, PH_SEP,
		PH_BLEN, PH_BODY, PH_TAIL_TS, PH_TAIL_CMD, PH_DONE_TS, PH_DONE_CMD, PH_BAD
	} phase_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic [7:0]           obyte;
		logic [1:0]           status;
		logic [31:0]          verb;
		logic [62:0]          stamp;
		logic [LEN_WIDTH-1:0] ulen;
		logic [LEN_WIDTH-1:0] blen;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] v;
		if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
		else v = 5'd16;
		return v;
	endfunction

	function automatic logic [CI_W-1:0] clamp_len(input logic [3:0] n);
		logic [CI_W-1:0] r;
		if (n == 4'd0) r = CI_W'(1);
		else if (32'(n) > COOKIE_MAX) r = CI_W'(COOKIE_MAX);
		else r = CI_W'(n);
		return r;
	endfunction

endpackage

// ===== rtl/lrlp_front.sv =====
// front end: configuration, byte acceptance and line parsing
module lrlp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	input  lrlp_pkg::queue_stat_t qstat,
	output logic                 push,
	output lrlp_pkg::result_t    push_item
);

	logic [63:0] head_cookie_q, tail_cookie_q;
	logic [3:0]  head_len_q, tail_len_q;
	logic [7:0]  mark_q, stamp_q;

	lrlp_pkg::phase_t                  phase_q, ph_n;
	logic [lrlp_pkg::CI_W-1:0]         ci_q, ci_n, ci_inc, hl, tl;
	logic                              hm_q, hm_n;
	logic [lrlp_pkg::ACC_W-1:0]        acc_q, acc_n, acc_sh;
	logic [lrlp_pkg::FC_W-1:0]         fc_q, fc_n, fc_inc;
	logic [31:0]                       verb_q, verb_n;
	logic [lrlp_pkg::LEN_WIDTH-1:0]    ulen_q, ulen_n, bl_q, bl_n, blen_q, blen_n;
	logic [4:0]                        hv;
	logic                              dig_ok, fit32, fit63, fitlen;
	logic                              emit, fire, is_lf, short_line;
	logic [1:0]                        emit_kind;
	logic [7:0]                        head_ch, tail_ch;

	assign in_stall = qstat.full;
	assign fire     = in_valid && !in_stall;
	assign is_lf    = (data_byte == lrlp_pkg::CH_LF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_cookie_q <= '0;
			tail_cookie_q <= '0;
			head_len_q    <= 4'd1;
			tail_len_q    <= 4'd1;
			mark_q        <= '0;
			stamp_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lrlp_pkg::CFG_HEAD_COOKIE:     head_cookie_q <= cfg_data;
				lrlp_pkg::CFG_HEAD_COOKIE_LEN: head_len_q    <= cfg_data[3:0];
				lrlp_pkg::CFG_TAIL_COOKIE:     tail_cookie_q <= cfg_data;
				lrlp_pkg::CFG_TAIL_COOKIE_LEN: tail_len_q    <= cfg_data[3:0];
				lrlp_pkg::CFG_MARK_CHAR:       mark_q        <= cfg_data[7:0];
				lrlp_pkg::CFG_STAMP_CHAR:      stamp_q       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign hl      = lrlp_pkg::clamp_len(head_len_q);
	assign tl      = lrlp_pkg::clamp_len(tail_len_q);
	assign ci_inc  = ci_q + lrlp_pkg::CI_W'(1);
	assign head_ch = head_cookie_q[8*ci_q[lrlp_pkg::CSEL_W-1:0] +: 8];
	assign tail_ch = tail_cookie_q[8*ci_q[lrlp_pkg::CSEL_W-1:0] +: 8];
	assign hv      = lrlp_pkg::hex_val(data_byte);
	assign fc_inc  = fc_q + lrlp_pkg::FC_W'(1);
	assign dig_ok  = (hv != 5'd16) &&
		(32'(fc_inc) < lrlp_pkg::NUMBER_FIELD_CHARS);
	assign fit32   = (acc_q[lrlp_pkg::ACC_W-1:28] == '0);
	assign fit63   = (acc_q[lrlp_pkg::ACC_W-1:59] == '0);
	assign fitlen  = (acc_q[lrlp_pkg::ACC_W-1:lrlp_pkg::LEN_WIDTH-4] == '0);
	assign acc_sh  = {acc_q[lrlp_pkg::ACC_W-5:0], hv[3:0]};
	assign short_line = (phase_q == lrlp_pkg::PH_HEAD) && (ci_inc < hl);

	always_comb begin
		ph_n      = phase_q;
		ci_n      = ci_q;
		hm_n      = hm_q;
		acc_n     = acc_q;
		fc_n      = fc_q;
		verb_n    = verb_q;
		ulen_n    = ulen_q;
		bl_n      = bl_q;
		blen_n    = blen_q;
		emit      = 1'b0;
		emit_kind = lrlp_pkg::KIND_URI;
		unique case (phase_q)
			lrlp_pkg::PH_HEAD: begin
				if (data_byte != head_ch) hm_n = 1'b1;
				ci_n = ci_inc;
				if (ci_inc >= hl) begin
					ph_n  = (hm_q || data_byte != head_ch) ? lrlp_pkg::PH_BAD
						: lrlp_pkg::PH_FIRST;
					acc_n = '0;
					fc_n  = '0;
				end
			end
			lrlp_pkg::PH_FIRST: begin
				if (data_byte == lrlp_pkg::CH_SPACE) ph_n = lrlp_pkg::PH_BAD;
				else if (data_byte == mark_q) begin
					fc_n = lrlp_pkg::FC_W'(1);
					ph_n = lrlp_pkg::PH_TIME;
				end else if (dig_ok && fit32) begin
					fc_n  = fc_inc;
					acc_n = acc_sh;
					ph_n  = lrlp_pkg::PH_VERB;
				end else ph_n = lrlp_pkg::PH_BAD;
			end
			lrlp_pkg::PH_VERB: begin
				if (data_byte == lrlp_pkg::CH_SPACE) begin
					verb_n = acc_q[31:0];
					acc_n  = '0;
					fc_n   = '0;
					ph_n   = lrlp_pkg::PH_ULEN;
				end else if (dig_ok && fit32) begin
					fc_n  = fc_inc;
					acc_n = acc_sh;
				end else ph_n = lrlp_pkg::PH_BAD;
			end
			lrlp_pkg::PH_TIME: begin
				if (data_byte == lrlp_pkg::CH_SPACE) begin
					ph_n = (fc_q < lrlp_pkg::FC_W'(2) || acc_q == '0) ? lrlp_pkg::PH_BAD
						: lrlp_pkg::PH_STAMP;
				end else if (dig_ok && fit63) begin
					fc_n  = fc_inc;
					acc_n = acc_sh;
				end else ph_n = lrlp_pkg::PH_BAD;
			end
			lrlp_pkg::PH_STAMP: begin
				if (data_byte == stamp_q) begin
					ph_n = lrlp_pkg::PH_TAIL_TS;
					ci_n = '0;
				end else ph_n = lrlp_pkg::PH_BAD;
			end
			lrlp_pkg::PH_ULEN: begin
				if (data_byte == lrlp_pkg::CH_COLON) begin
					if (fc_q == '0 || acc_q == '0) ph_n = lrlp_pkg::PH_BAD;
					else begin
						ulen_n = acc_q[lrlp_pkg::LEN_WIDTH-1:0];
						bl_n   = acc_q[lrlp_pkg::LEN_WIDTH-1:0];
						acc_n  = '0;
						fc_n   = '0;
						ph_n   = lrlp_pkg::PH_URI;
					end
				end else if (dig_ok && fitlen) begin
					fc_n  = fc_inc;
					acc_n = acc_sh;
				end else ph_n = lrlp_pkg::PH_BAD;
			end
			lrlp_pkg::PH_URI: begin
				emit      = 1'b1;
				emit_kind = lrlp_pkg::KIND_URI;
				bl_n      = bl_q - lrlp_pkg::LEN_WIDTH'(1);
				if (bl_q == lrlp_pkg::LEN_WIDTH'(1)) ph_n = lrlp_pkg::PH_SEP;
			end
			lrlp_pkg::PH_SEP: begin
				ph_n = (data_byte == lrlp_pkg::CH_SPACE) ? lrlp_pkg::PH_BLEN
					: lrlp_pkg::PH_BAD;
			end
			lrlp_pkg::PH_BLEN: begin
				if (data_byte == lrlp_pkg::CH_COLON) begin
					if (fc_q == '0) ph_n = lrlp_pkg::PH_BAD;
					else begin
						blen_n = acc_q[lrlp_pkg::LEN_WIDTH-1:0];
						bl_n   = acc_q[lrlp_pkg::LEN_WIDTH-1:0];
						acc_n  = '0;
						fc_n   = '0;
						ci_n   = '0;
						ph_n   = (acc_q == '0) ? lrlp_pkg::PH_TAIL_CMD : lrlp_pkg::PH_BODY;
					end
				end else if (dig_ok && fitlen) begin
					fc_n  = fc_inc;
					acc_n = acc_sh;
				end else ph_n = lrlp_pkg::PH_BAD;
			end
			lrlp_pkg::PH_BODY: begin
				emit      = 1'b1;
				emit_kind = lrlp_pkg::KIND_BODY;
				bl_n      = bl_q - lrlp_pkg::LEN_WIDTH'(1);
				if (bl_q == lrlp_pkg::LEN_WIDTH'(1)) begin
					ph_n = lrlp_pkg::PH_TAIL_CMD;
					ci_n = '0;
				end
			end
			lrlp_pkg::PH_TAIL_TS, lrlp_pkg::PH_TAIL_CMD: begin
				if (data_byte != tail_ch) ph_n = lrlp_pkg::PH_BAD;
				else begin
					ci_n = ci_inc;
					if (ci_inc >= tl) begin
						ph_n = (phase_q == lrlp_pkg::PH_TAIL_TS) ? lrlp_pkg::PH_DONE_TS
							: lrlp_pkg::PH_DONE_CMD;
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		push_item = '0;
		push      = 1'b0;
		if (fire) begin
			if (!is_lf) begin
				push            = emit;
				push_item.kind  = emit_kind;
				push_item.obyte = data_byte;
			end else begin
				push           = 1'b1;
				push_item.kind = lrlp_pkg::KIND_STATUS;
				if (short_line) push_item.status = lrlp_pkg::ST_SHORT;
				else if (ph_n == lrlp_pkg::PH_DONE_CMD) begin
					push_item.status = lrlp_pkg::ST_CMD;
					push_item.verb   = verb_n;
					push_item.ulen   = ulen_n;
					push_item.blen   = blen_n;
				end else if (ph_n == lrlp_pkg::PH_DONE_TS) begin
					push_item.status = lrlp_pkg::ST_TS;
					push_item.stamp  = acc_n[62:0];
				end else push_item.status = lrlp_pkg::ST_BAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lrlp_pkg::PH_HEAD;
			ci_q    <= '0;
			hm_q    <= 1'b0;
			acc_q   <= '0;
			fc_q    <= '0;
			verb_q  <= '0;
			ulen_q  <= '0;
			bl_q    <= '0;
			blen_q  <= '0;
		end else if (fire) begin
			if (is_lf) begin
				phase_q <= lrlp_pkg::PH_HEAD;
				ci_q    <= '0;
				hm_q    <= 1'b0;
				acc_q   <= '0;
				fc_q    <= '0;
				verb_q  <= '0;
				ulen_q  <= '0;
				bl_q    <= '0;
				blen_q  <= '0;
			end else begin
				phase_q <= ph_n;
				ci_q    <= ci_n;
				hm_q    <= hm_n;
				acc_q   <= acc_n;
				fc_q    <= fc_n;
				verb_q  <= verb_n;
				ulen_q  <= ulen_n;
				bl_q    <= bl_n;
				blen_q  <= blen_n;
			end
		end
	end

endmodule

// ===== rtl/lrlp_queue.sv =====
// short result queue between the parser and the output stage
module lrlp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  lrlp_pkg::result_t     push_item,
	input  logic                  pop,
	output lrlp_pkg::result_t     head_item,
	output lrlp_pkg::queue_stat_t qstat
);

	lrlp_pkg::result_t             mem_q [lrlp_pkg::QUEUE_DEPTH];
	logic [lrlp_pkg::QPTR_W-1:0]   wr_q, rd_q;
	logic [lrlp_pkg::QPTR_W:0]     cnt_q;
	logic                          do_pop;

	assign qstat.full  = (cnt_q == (lrlp_pkg::QPTR_W+1)'(lrlp_pkg::QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign do_pop      = pop && !qstat.empty;
	assign head_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + lrlp_pkg::QPTR_W'(1);
			if (do_pop) rd_q <= rd_q + lrlp_pkg::QPTR_W'(1);
			cnt_q <= cnt_q + (lrlp_pkg::QPTR_W+1)'(push) - (lrlp_pkg::QPTR_W+1)'(do_pop);
		end
	end

endmodule

// ===== rtl/lrlp_back.sv =====
// back end: output register that drains the result queue
module lrlp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lrlp_pkg::queue_stat_t qstat,
	input  lrlp_pkg::result_t     head_item,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output lrlp_pkg::result_t     out_item
);

	logic              valid_q;
	lrlp_pkg::result_t item_q;
	logic              load;

	assign load      = !valid_q || !out_stall;
	assign pop       = load && !qstat.empty;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (load) valid_q <= !qstat.empty;
	end

	always_ff @(posedge clk) begin
		if (pop) item_q <= head_item;
	end

endmodule

// ===== rtl/log_record_line_parser.sv =====
// top level of the log record line parser
// throughput: one byte per cycle while in_stall is low, set by the parser state update
// path: a result is written into the queue as its byte is taken, then moves to the output register
// a four-entry result queue and an output register decouple the two sides
// reset: asynchronous, clears line state, queue and output valid;
// configuration returns to its reset values
module log_record_line_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    data_byte,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [63:0]                   cfg_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    out_kind,
	output logic [7:0]                    out_byte,
	output logic [1:0]                    status,
	output logic [31:0]                   verb,
	output logic [62:0]                   stamp_value,
	output logic [lrlp_pkg::LEN_WIDTH-1:0] uri_length,
	output logic [lrlp_pkg::LEN_WIDTH-1:0] body_length
);

	lrlp_pkg::queue_stat_t qstat;
	lrlp_pkg::result_t     push_item, head_item, out_item;
	logic                  push, pop;

	lrlp_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .data_byte,
		.cfg_we, .cfg_index, .cfg_data, .qstat, .push, .push_item
	);

	lrlp_queue u_queue (
		.clk, .arst_n, .push, .push_item, .pop, .head_item, .qstat
	);

	lrlp_back u_back (
		.clk, .arst_n, .qstat, .head_item, .pop, .out_valid, .out_stall, .out_item
	);

	assign out_kind    = out_item.kind;
	assign out_byte    = out_item.obyte;
	assign status      = out_item.status;
	assign verb        = out_item.verb;
	assign stamp_value = out_item.stamp;
	assign uri_length  = out_item.ulen;
	assign body_length = out_item.blen;

endmodule

// ===== rtl/lrlp_checker.sv =====
// port-level assertions of the log record line parser and their binding
`include "assert_macros.svh"

module lrlp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [1:0]                    out_kind,
	input logic [1:0]                    status,
	input logic [31:0]                   verb,
	input logic [62:0]                   stamp_value,
	input logic [lrlp_pkg::LEN_WIDTH-1:0] uri_length,
	input logic [lrlp_pkg::LEN_WIDTH-1:0] body_length
);

	`LRLP_ASSERT_NEXT(a_hold_valid, clk, arst_n, out_valid && out_stall, out_valid)
	`LRLP_ASSERT_NOW(a_kind_legal, clk, arst_n, out_valid, out_kind != 2'd3)
	`LRLP_ASSERT_NOW(a_byte_clean, clk, arst_n, out_valid && out_kind != lrlp_pkg::KIND_STATUS, status == lrlp_pkg::ST_CMD && verb == '0 && stamp_value == '0)
	`LRLP_ASSERT_NOW(a_cmd_uri, clk, arst_n, out_valid && out_kind == lrlp_pkg::KIND_STATUS && status == lrlp_pkg::ST_CMD, uri_length != '0 && stamp_value == '0)
	`LRLP_ASSERT_NOW(a_other_clean, clk, arst_n, out_valid && out_kind == lrlp_pkg::KIND_STATUS && status != lrlp_pkg::ST_CMD, verb == '0 && uri_length == '0 && body_length == '0)

endmodule

bind log_record_line_parser lrlp_checker u_lrlp_checker (
	.clk, .arst_n, .out_valid, .out_stall, .out_kind, .status, .verb,
	.stamp_value, .uri_length, .body_length
);
